### hdl/svalloc_pkg.sv
// Shared types, sizes and codes for the synthesizer voice allocator.
// No dependencies; every other file in this folder uses this package.

package svalloc_pkg;

  // Sizing of the voice bank and the age stamps.
  localparam int NUM_VOICES = 16;
  localparam int AGE_BITS   = 32;
  localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // Field widths of the channels.
  localparam int REQ_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int VOICE_W = 4;
  localparam int ACT_W   = 3;
  localparam int MODE_W  = 2;

  // At most this many results leave for one event.
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MODE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICING_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_EN     = 1'd1;

  // Event types.
  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SUSTAIN  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ALL_OFF  = 2'd3;

  // Voice actions.
  localparam logic [ACT_W-1:0] ACT_RESET_TRIG = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TRIG       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SLIDE      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GATE_OFF   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_KILL       = 3'd4;

  // Voicing modes; the unused code behaves as plain mono.
  localparam logic [MODE_W-1:0] MODE_POLY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEGATO = 2'd2;

  // One result item.
  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [ACT_W-1:0]   action;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
    logic               fade_in;
    logic               keep_glide;
  } result_t;

  // Sequencer to output stage.
  typedef struct packed {
    logic    push;
    logic    flush;
    result_t res;
  } emit_req_t;

  // Output stage back to the sequencer.
  typedef struct packed {
    logic can_push;
    logic idle;
  } emit_sts_t;

endpackage

### hdl/svalloc_out_stage.sv
// Result output stage of the voice allocator: a pending slot plus the output register.
// Depends on svalloc_pkg. The pending slot lets the last flag be set on the final result.

module svalloc_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  svalloc_pkg::emit_req_t req_i,
  output svalloc_pkg::emit_sts_t sts_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output svalloc_pkg::result_t   res_o,
  output logic                   last_o
);

  logic                 pend_valid_q, pend_valid_d;
  svalloc_pkg::result_t pend_res_q, pend_res_d;
  logic                 out_valid_q, out_valid_d;
  svalloc_pkg::result_t out_res_q, out_res_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free;

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_res_d   = pend_res_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    out_last_d   = out_last_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (req_i.push) begin
      // A newer result exists, so the pending one is not the last.
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_res_d   = pend_res_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_res_d   = req_i.res;
    end else if (req_i.flush && pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_res_d    = pend_res_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.can_push = !pend_valid_q || out_free;
  assign sts_o.idle     = !pend_valid_q;
  assign out_valid_o    = out_valid_q;
  assign res_o          = out_res_q;
  assign last_o         = out_last_q;

endmodule

### hdl/synth_voice_allocator_unit.sv
// Top level of the synthesizer voice allocator: voice state, event sequencer, voice scan.
// Depends on svalloc_pkg and svalloc_out_stage.
//
//   Channel   Dir  Transfer when             Payload
//   in        in   in_valid_i & !in_stall_o  req_type, note, velocity, pedal_down, immediate
//   out       out  out_valid_o & !out_stall_i voice, action, note_out, velocity_out, fade_in,
//                                            keep_glide, last
//   cfg       in   cfg_wr_en_i               cfg_index_i selects, cfg_data_i holds the value
//
// A poly note-on goes through these steps from one input transfer to the next: accept,
// scan the voices one per cycle, commit, hand its single result to the output register
// and see the pending slot empty. Note-off, pedal release and all-notes-off also scan
// the voices; mono note-ons and pedal events without a release skip the scan. A stalled
// output can hold up the scan and the final hand-off. The poly scan runs through the
// shared age comparator. Reset clears all voice state at once; no clearing pass is
// needed. An output stall holds the scan on the voice whose result cannot yet be handed
// over.

module synth_voice_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes.
  input  logic                                cfg_wr_en_i,
  input  logic [svalloc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [svalloc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Event input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [svalloc_pkg::REQ_W-1:0]       req_type_i,
  input  logic [svalloc_pkg::NOTE_W-1:0]      note_i,
  input  logic [svalloc_pkg::VEL_W-1:0]       velocity_i,
  input  logic                                pedal_down_i,
  input  logic                                immediate_i,
  // Result output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [svalloc_pkg::VOICE_W-1:0]     voice_o,
  output logic [svalloc_pkg::ACT_W-1:0]       action_o,
  output logic [svalloc_pkg::NOTE_W-1:0]      note_out_o,
  output logic [svalloc_pkg::VEL_W-1:0]       velocity_out_o,
  output logic                                fade_in_o,
  output logic                                keep_glide_o,
  output logic                                last_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PICK   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [svalloc_pkg::IDX_W-1:0] LAST_IDX =
    svalloc_pkg::IDX_W'(svalloc_pkg::NUM_VOICES - 1);
  localparam logic [svalloc_pkg::AGE_BITS-1:0] AGE_MAX = {svalloc_pkg::AGE_BITS{1'b1}};

  // Configuration registers.
  logic [svalloc_pkg::MODE_W-1:0] mode_q;
  logic                           glide_en_q;

  // Voice state. Reset gives every field its cleared value, so no valid bits are needed.
  logic [svalloc_pkg::NUM_VOICES-1:0] active_q;
  logic [svalloc_pkg::NUM_VOICES-1:0] held_q;
  logic [svalloc_pkg::NOTE_W-1:0]     vnote_q [svalloc_pkg::NUM_VOICES];
  logic [svalloc_pkg::AGE_BITS-1:0]   age_q   [svalloc_pkg::NUM_VOICES];
  logic [svalloc_pkg::AGE_BITS-1:0]   note_ctr_q, note_ctr_d;
  logic                               sustain_q, sustain_d;

  // Sequencer.
  logic [2:0]                       state_q, state_d;
  logic [svalloc_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic [svalloc_pkg::CNT_W-1:0]    emitted_q, emitted_d;

  // The event being worked on.
  logic [svalloc_pkg::REQ_W-1:0]    item_req_q, item_req_d;
  logic [svalloc_pkg::NOTE_W-1:0]   item_note_q, item_note_d;
  logic [svalloc_pkg::VEL_W-1:0]    item_vel_q, item_vel_d;
  logic                             item_imm_q, item_imm_d;

  // Voice choice for a poly note-on, built up over the scan.
  logic                             match_found_q, match_found_d;
  logic [svalloc_pkg::IDX_W-1:0]    match_idx_q, match_idx_d;
  logic                             free_found_q, free_found_d;
  logic [svalloc_pkg::IDX_W-1:0]    free_idx_q, free_idx_d;
  logic                             best_valid_q, best_valid_d;
  logic                             best_rel_q, best_rel_d;
  logic [svalloc_pkg::IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [svalloc_pkg::AGE_BITS-1:0] best_age_q, best_age_d;

  // Voice state write strobes.
  logic                             start_en;
  logic [svalloc_pkg::IDX_W-1:0]    start_idx;
  logic [svalloc_pkg::NOTE_W-1:0]   start_note;
  logic                             scan_upd;
  logic                             clr_held;
  logic                             clr_active;

  // Values seen at the voice under the scan pointer.
  logic                             sel_active;
  logic                             sel_held;
  logic [svalloc_pkg::NOTE_W-1:0]   sel_note;
  logic [svalloc_pkg::AGE_BITS-1:0] sel_age;
  logic                             age_less;
  logic [svalloc_pkg::AGE_BITS-1:0] next_age;
  logic [svalloc_pkg::IDX_W-1:0]    pick_idx;

  svalloc_pkg::emit_req_t emit_req;
  svalloc_pkg::emit_sts_t emit_sts;
  svalloc_pkg::result_t   out_res;

  assign sel_active = active_q[cnt_q];
  assign sel_held   = held_q[cnt_q];
  assign sel_note   = vnote_q[cnt_q];
  assign sel_age    = age_q[cnt_q];

  // The one shared comparator of the voice scan.
  assign age_less = sel_age < best_age_q;

  // The note counter saturates; a started voice takes the advanced value as its age.
  assign next_age = (note_ctr_q != AGE_MAX) ? note_ctr_q + 1'b1 : note_ctr_q;

  // Priority of the poly choice: same note, then a free voice, then the stealing rank.
  assign pick_idx = match_found_q ? match_idx_q : (free_found_q ? free_idx_q : best_idx_q);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    logic hit;
    logic emit_ok;
    logic want;
    logic better;
    logic cand_rel;

    state_d       = state_q;
    cnt_d         = cnt_q;
    emitted_d     = emitted_q;
    item_req_d    = item_req_q;
    item_note_d   = item_note_q;
    item_vel_d    = item_vel_q;
    item_imm_d    = item_imm_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    best_valid_d  = best_valid_q;
    best_rel_d    = best_rel_q;
    best_idx_d    = best_idx_q;
    best_age_d    = best_age_q;
    note_ctr_d    = note_ctr_q;
    sustain_d     = sustain_q;

    start_en   = 1'b0;
    start_idx  = '0;
    start_note = item_note_q;
    scan_upd   = 1'b0;
    clr_held   = 1'b0;
    clr_active = 1'b0;

    emit_req       = '0;
    hit            = 1'b0;
    emit_ok        = 1'b0;
    want           = 1'b0;
    better         = 1'b0;
    cand_rel       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_req_d    = req_type_i;
          item_note_d   = note_i;
          item_vel_d    = velocity_i;
          item_imm_d    = immediate_i;
          cnt_d         = '0;
          emitted_d     = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          best_valid_d  = 1'b0;
          state_d       = ST_DONE;
          case (req_type_i)
            svalloc_pkg::REQ_NOTE_ON: begin
              if (mode_q == svalloc_pkg::MODE_POLY) begin
                state_d = ST_PICK;
              end else begin
                // Mono and legato always play on voice 0.
                start_en                = 1'b1;
                start_idx               = '0;
                start_note              = note_i;
                note_ctr_d              = next_age;
                emit_req.push           = 1'b1;
                emit_req.res.voice      = '0;
                emit_req.res.action     = ((mode_q == svalloc_pkg::MODE_LEGATO) &&
                                           active_q[0] && held_q[0]) ?
                                          svalloc_pkg::ACT_SLIDE : svalloc_pkg::ACT_TRIG;
                emit_req.res.note       = note_i;
                emit_req.res.velocity   = velocity_i;
                emit_req.res.fade_in    = 1'b0;
                emit_req.res.keep_glide = active_q[0] && held_q[0];
              end
            end
            svalloc_pkg::REQ_NOTE_OFF: begin
              state_d = ST_SCAN;
            end
            svalloc_pkg::REQ_SUSTAIN: begin
              // Only a change of pedal state matters; a release gates off released voices.
              if (sustain_q != pedal_down_i) begin
                sustain_d = pedal_down_i;
                if (!pedal_down_i) begin
                  state_d = ST_SCAN;
                end
              end
            end
            default: begin
              sustain_d = 1'b0;
              state_d   = ST_SCAN;
            end
          endcase
        end
      end

      ST_PICK: begin
        if (sel_active && (sel_note == item_note_q) && !match_found_q) begin
          match_found_d = 1'b1;
          match_idx_d   = cnt_q;
        end
        if (!sel_active && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cnt_q;
        end
        // Rank: any released voice beats a held one, then the older age wins.
        // Ties keep the earlier, lower-indexed voice.
        cand_rel = !sel_held;
        better   = !best_valid_q || (cand_rel && !best_rel_q) ||
                   ((cand_rel == best_rel_q) && age_less);
        if (better) begin
          best_valid_d = 1'b1;
          best_rel_d   = cand_rel;
          best_idx_d   = cnt_q;
          best_age_d   = sel_age;
        end
        if (cnt_q == LAST_IDX) begin
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_COMMIT: begin
        // The pending slot is empty here, so the single result always goes in.
        start_en                = 1'b1;
        start_idx               = pick_idx;
        note_ctr_d              = next_age;
        emit_req.push           = 1'b1;
        emit_req.res.voice      = svalloc_pkg::VOICE_W'(pick_idx);
        emit_req.res.action     = svalloc_pkg::ACT_RESET_TRIG;
        emit_req.res.note       = item_note_q;
        emit_req.res.velocity   = item_vel_q;
        emit_req.res.fade_in    = active_q[pick_idx];
        emit_req.res.keep_glide = glide_en_q && active_q[pick_idx];
        state_d                 = ST_DONE;
      end

      ST_SCAN: begin
        case (item_req_q)
          svalloc_pkg::REQ_NOTE_OFF: begin
            hit      = sel_active && (sel_note == item_note_q) && sel_held;
            emit_ok  = !sustain_q;
            clr_held = 1'b1;
          end
          svalloc_pkg::REQ_SUSTAIN: begin
            hit     = sel_active && !sel_held;
            emit_ok = 1'b1;
          end
          default: begin
            hit        = sel_active;
            emit_ok    = 1'b1;
            clr_held   = 1'b1;
            clr_active = item_imm_q;
          end
        endcase
        want = hit && emit_ok && (emitted_q < svalloc_pkg::CNT_W'(svalloc_pkg::MAX_OUT));
        // Hold on this voice until the output stage can take its result.
        if (!want || emit_sts.can_push) begin
          scan_upd                = hit;
          emit_req.push           = want;
          emit_req.res.voice      = svalloc_pkg::VOICE_W'(cnt_q);
          emit_req.res.action     = ((item_req_q == svalloc_pkg::REQ_ALL_OFF) && item_imm_q) ?
                                    svalloc_pkg::ACT_KILL : svalloc_pkg::ACT_GATE_OFF;
          emit_req.res.note       = sel_note;
          emit_req.res.velocity   = '0;
          emit_req.res.fade_in    = 1'b0;
          emit_req.res.keep_glide = 1'b0;
          if (want) begin
            emitted_d = emitted_q + 1'b1;
          end
          if (cnt_q == LAST_IDX) begin
            state_d = ST_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      ST_DONE: begin
        // Release the held-back final result with its last flag.
        emit_req.flush = 1'b1;
        if (emit_sts.idle) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= svalloc_pkg::MODE_POLY;
      glide_en_q <= 1'b0;
      note_ctr_q <= '0;
      sustain_q  <= 1'b0;
      active_q   <= '0;
      held_q     <= '0;
      for (int i = 0; i < svalloc_pkg::NUM_VOICES; i++) begin
        vnote_q[i] <= '0;
        age_q[i]   <= '0;
      end
    end else begin
      state_q    <= state_d;
      note_ctr_q <= note_ctr_d;
      sustain_q  <= sustain_d;
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          svalloc_pkg::CFG_VOICING_MODE: mode_q     <= cfg_data_i;
          svalloc_pkg::CFG_GLIDE_EN:     glide_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_en) begin
        active_q[start_idx] <= 1'b1;
        held_q[start_idx]   <= 1'b1;
        vnote_q[start_idx]  <= start_note;
        age_q[start_idx]    <= next_age;
      end
      if (scan_upd) begin
        if (clr_held) begin
          held_q[cnt_q] <= 1'b0;
        end
        if (clr_active) begin
          active_q[cnt_q] <= 1'b0;
        end
      end
    end
  end

  // Working registers of the sequencer carry no reset; IDLE sets them before use.
  always_ff @(posedge clk_i) begin
    cnt_q         <= cnt_d;
    emitted_q     <= emitted_d;
    item_req_q    <= item_req_d;
    item_note_q   <= item_note_d;
    item_vel_q    <= item_vel_d;
    item_imm_q    <= item_imm_d;
    match_found_q <= match_found_d;
    match_idx_q   <= match_idx_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    best_valid_q  <= best_valid_d;
    best_rel_q    <= best_rel_d;
    best_idx_q    <= best_idx_d;
    best_age_q    <= best_age_d;
  end

  svalloc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .sts_o       (emit_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res),
    .last_o      (last_o)
  );

  assign voice_o        = out_res.voice;
  assign action_o       = out_res.action;
  assign note_out_o     = out_res.note;
  assign velocity_out_o = out_res.velocity;
  assign fade_in_o      = out_res.fade_in;
  assign keep_glide_o   = out_res.keep_glide;

endmodule

### hdl/svalloc_checker.sv
// Port-level checks for the voice allocator, attached to the top level by bind.
// Depends on svalloc_pkg and synth_voice_allocator_unit.

module svalloc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [svalloc_pkg::VOICE_W-1:0]     voice_o,
  input logic [svalloc_pkg::ACT_W-1:0]       action_o,
  input logic [svalloc_pkg::NOTE_W-1:0]      note_out_o,
  input logic [svalloc_pkg::VEL_W-1:0]       velocity_out_o,
  input logic                                fade_in_o,
  input logic                                keep_glide_o,
  input logic                                last_o
);

  // A result waiting under stall stays offered, with voice, action, note, velocity and last unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(voice_o) && $stable(action_o) &&
      $stable(note_out_o) && $stable(velocity_out_o) && $stable(last_o))
    else $error("stalled result changed");

  // Every accepted event keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("event accepted without the block turning busy");

  // The result of a poly note-on is its only one, so it is always marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == svalloc_pkg::ACT_RESET_TRIG) |-> last_o)
    else $error("poly start result not marked last");

  // Gate-off and kill results carry no start information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((action_o == svalloc_pkg::ACT_GATE_OFF) ||
                    (action_o == svalloc_pkg::ACT_KILL))
      |-> (velocity_out_o == '0) && !fade_in_o && !keep_glide_o)
    else $error("release result carries start fields");

endmodule

bind synth_voice_allocator_unit svalloc_checker u_svalloc_checker (.*);

### test/synth_voice_allocator_unit_tb.sv
// Testbench for synth_voice_allocator_unit: random and directed MIDI-style events,
// with every voice command checked against a scoreboard that tracks voice allocation.
// Depends on svalloc_pkg and the allocator RTL only.

module synth_voice_allocator_unit_tb;
  import svalloc_pkg::*;

  // The spare voicing code is accepted by the block and must act as plain mono.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_EVENTS   = 320;
  localparam int NUM_PHASES      = 6;
  // A scan plus commit and hand-off, taken twice over, covers events with no result.
  localparam int SETTLE_CYCLES   = 2 * (NUM_VOICES + 3);
  // Long output hold-off that lets the block fill up and stall its input.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 250;
  localparam int TIMEOUT_CYCLES  = 400000;

  // One voice command as it leaves the block, the last flag included.
  typedef struct packed {
    result_t res;
    logic    last;
  } voice_cmd_t;

  // Allocation scoreboard: keeps its own copy of the voice bank and the registers,
  // turns each accepted event into the voice commands it must cause, and checks
  // the commands the block hands over against them in order.
  class voice_alloc_scoreboard;
    logic [MODE_W-1:0]   mode;
    logic                glide_en;
    logic                active [NUM_VOICES];
    logic                held [NUM_VOICES];
    logic [NOTE_W-1:0]   note_of [NUM_VOICES];
    logic [AGE_BITS-1:0] age_of [NUM_VOICES];
    logic [AGE_BITS-1:0] age_counter;
    logic                pedal;
    voice_cmd_t          pending_cmds[$];
    int                  mismatches;

    function new();
      mode        = MODE_POLY;
      glide_en    = 1'b0;
      age_counter = '0;
      pedal       = 1'b0;
      mismatches  = 0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        active[i]  = 1'b0;
        held[i]    = 1'b0;
        note_of[i] = '0;
        age_of[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_VOICING_MODE) begin
        mode = val[MODE_W-1:0];
      end else begin
        glide_en = val[0];
      end
    endfunction

    // The age counter saturates instead of wrapping.
    function logic [AGE_BITS-1:0] stamp_age();
      if (age_counter != '1) age_counter++;
      return age_counter;
    endfunction

    // Same note first, then the lowest free voice, then the oldest released voice,
    // then the oldest voice of all. Ties go to the lowest index.
    function int choose_voice(logic [NOTE_W-1:0] nt);
      int                  best;
      logic [AGE_BITS-1:0] best_age;
      best     = -1;
      best_age = '0;
      for (int i = 0; i < NUM_VOICES; i++)
        if (active[i] && note_of[i] == nt) return i;
      for (int i = 0; i < NUM_VOICES; i++)
        if (!active[i]) return i;
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (!held[i] && (best < 0 || age_of[i] < best_age)) begin
          best     = i;
          best_age = age_of[i];
        end
      end
      if (best >= 0) return best;
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (best < 0 || age_of[i] < best_age) begin
          best     = i;
          best_age = age_of[i];
        end
      end
      return best;
    endfunction

    function voice_cmd_t make_cmd(int v, logic [ACT_W-1:0] act, logic [NOTE_W-1:0] nt,
                                  logic [VEL_W-1:0] vel, logic fade, logic keep);
      voice_cmd_t c;
      c.res.voice      = VOICE_W'(v);
      c.res.action     = act;
      c.res.note       = nt;
      c.res.velocity   = vel;
      c.res.fade_in    = fade;
      c.res.keep_glide = keep;
      c.last           = 1'b0;
      return c;
    endfunction

    function void note_event(logic [REQ_W-1:0] kind, logic [NOTE_W-1:0] nt,
                             logic [VEL_W-1:0] vel, logic down, logic imm);
      voice_cmd_t cmds[$];
      voice_cmd_t tail;
      int         v;
      logic       steal;
      logic       sounding;
      case (kind)
        REQ_NOTE_ON: begin
          if (mode != MODE_POLY) begin
            // Mono and legato always play on voice 0.
            sounding = active[0] && held[0];
            cmds.push_back(make_cmd(0, (mode == MODE_LEGATO && sounding) ? ACT_SLIDE : ACT_TRIG,
                                    nt, vel, 1'b0, sounding));
            v = 0;
          end else begin
            v     = choose_voice(nt);
            steal = active[v];
            cmds.push_back(make_cmd(v, ACT_RESET_TRIG, nt, vel, steal, glide_en && steal));
          end
          note_of[v] = nt;
          held[v]    = 1'b1;
          active[v]  = 1'b1;
          age_of[v]  = stamp_age();
        end
        REQ_NOTE_OFF: begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (active[i] && held[i] && note_of[i] == nt) begin
              held[i] = 1'b0;
              if (!pedal) cmds.push_back(make_cmd(i, ACT_GATE_OFF, note_of[i], '0, 1'b0, 1'b0));
            end
          end
        end
        REQ_SUSTAIN: begin
          if (pedal != down) begin
            pedal = down;
            if (!down) begin
              for (int i = 0; i < NUM_VOICES; i++)
                if (active[i] && !held[i])
                  cmds.push_back(make_cmd(i, ACT_GATE_OFF, note_of[i], '0, 1'b0, 1'b0));
            end
          end
        end
        default: begin
          pedal = 1'b0;
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (active[i]) begin
              held[i] = 1'b0;
              cmds.push_back(make_cmd(i, imm ? ACT_KILL : ACT_GATE_OFF, note_of[i], '0,
                                      1'b0, 1'b0));
              if (imm) active[i] = 1'b0;
            end
          end
        end
      endcase
      while (cmds.size() > MAX_OUT) void'(cmds.pop_back());
      if (cmds.size() > 0) begin
        tail      = cmds.pop_back();
        tail.last = 1'b1;
        cmds.push_back(tail);
      end
      foreach (cmds[k]) pending_cmds.push_back(cmds[k]);
    endfunction

    function string describe(voice_cmd_t c);
      return $sformatf("voice=%0d action=%0d note=%0d vel=%0d fade=%0b keep=%0b last=%0b",
                       c.res.voice, c.res.action, c.res.note, c.res.velocity,
                       c.res.fade_in, c.res.keep_glide, c.last);
    endfunction

    function void check_command(voice_cmd_t got);
      voice_cmd_t want;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected voice command: %s", describe(got));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.res.voice !== want.res.voice || got.res.action !== want.res.action ||
          got.res.note !== want.res.note || got.res.velocity !== want.res.velocity ||
          got.res.fade_in !== want.res.fade_in ||
          got.res.keep_glide !== want.res.keep_glide || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("voice command mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_wr_en_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i     = REQ_NOTE_ON;
  logic [NOTE_W-1:0]     note_i         = '0;
  logic [VEL_W-1:0]      velocity_i     = '0;
  logic                  pedal_down_i   = 1'b0;
  logic                  immediate_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [VOICE_W-1:0]    voice_o;
  logic [ACT_W-1:0]      action_o;
  logic [NOTE_W-1:0]     note_out_o;
  logic [VEL_W-1:0]      velocity_out_o;
  logic                  fade_in_o;
  logic                  keep_glide_o;
  logic                  last_o;

  voice_alloc_scoreboard sb;

  // Idle rates of the two sides, stepped through as events are accepted:
  // first a frequent sender against a receiver that stalls often, then the reverse, then no idling.
  int send_idle_pct   = 36;
  int recv_idle_pct   = 79;
  int accepted_events = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  synth_voice_allocator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .note_i        (note_i),
    .velocity_i    (velocity_i),
    .pedal_down_i  (pedal_down_i),
    .immediate_i   (immediate_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .voice_o       (voice_o),
    .action_o      (action_o),
    .note_out_o    (note_out_o),
    .velocity_out_o(velocity_out_o),
    .fade_in_o     (fade_in_o),
    .keep_glide_o  (keep_glide_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall, changed at the falling edge. Once the sender runs flat out,
  // the receiver holds off for a long stretch so that results back up into the
  // block and it has to stall its input.
  always @(negedge clk_i) begin
    if (!hold_done && accepted_events >= HOLD_OFF_AT) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Every output transfer is checked at the rising edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_command({voice_o, action_o, note_out_o, velocity_out_o, fade_in_o,
                        keep_glide_o, last_o});
  end

  // Offers one event after a random number of idle cycles and holds it until the
  // transfer happens. Entered and left at a falling edge. Valid stays high into
  // the next event when that one comes without a gap.
  task automatic send_event(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] nt,
                            input logic [VEL_W-1:0] vel, input logic down, input logic imm);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    req_type_i   = kind;
    note_i       = nt;
    velocity_i   = vel;
    pedal_down_i = down;
    immediate_i  = imm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_event(kind, nt, vel, down, imm);
    accepted_events++;
    if (accepted_events >= 230) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (accepted_events >= 115) begin
      send_idle_pct = 79;
      recv_idle_pct = 36;
    end
    @(negedge clk_i);
  endtask

  // Random events are mostly note traffic on a narrow band of keys, so that
  // note-offs find their voices and the bank fills up and has to steal. One note
  // in five is drawn from the whole range so that every note bit toggles.
  task automatic send_random_event(input int band_lo);
    int               roll;
    logic [NOTE_W-1:0] nt;
    logic [REQ_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) nt = NOTE_W'($urandom_range(0, 127));
    else nt = NOTE_W'(band_lo + $urandom_range(0, 21));
    if (roll < 52) kind = REQ_NOTE_ON;
    else if (roll < 82) kind = REQ_NOTE_OFF;
    else if (roll < 97) kind = REQ_SUSTAIN;
    else kind = REQ_ALL_OFF;
    send_event(kind, nt, VEL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // Waits until every expected command has arrived and then lets the block finish
  // any event that causes no command, so that registers change only while idle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0] phase_mode [NUM_PHASES];
    logic              phase_glide [NUM_PHASES];
    int                band_lo;
    phase_mode  = '{MODE_POLY, MODE_POLY, MODE_MONO, MODE_LEGATO, MODE_SPARE, MODE_POLY};
    phase_glide = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) drain();
      write_reg(CFG_VOICING_MODE, CFG_DATA_W'(phase_mode[p]));
      write_reg(CFG_GLIDE_EN, CFG_DATA_W'(phase_glide[p]));

      if (p == 0) begin
        // Poly basics from an empty bank: note and velocity extremes, reuse of the
        // voice already on a note, note-off under the pedal, a repeated pedal state,
        // pedal release, a note-off that matches nothing, both all-notes-off kinds.
        send_event(REQ_NOTE_ON, 7'd0, 7'd127, 1'b0, 1'b0);
        send_event(REQ_NOTE_ON, 7'd127, 7'd0, 1'b1, 1'b1);
        send_event(REQ_NOTE_ON, 7'd0, 7'd64, 1'b0, 1'b0);
        send_event(REQ_SUSTAIN, 7'd0, 7'd0, 1'b1, 1'b0);
        send_event(REQ_NOTE_OFF, 7'd127, 7'd0, 1'b0, 1'b0);
        send_event(REQ_SUSTAIN, 7'd0, 7'd0, 1'b1, 1'b0);
        send_event(REQ_SUSTAIN, 7'd0, 7'd0, 1'b0, 1'b0);
        send_event(REQ_NOTE_OFF, 7'd0, 7'd0, 1'b0, 1'b0);
        send_event(REQ_NOTE_OFF, 7'd5, 7'd0, 1'b0, 1'b0);
        send_event(REQ_NOTE_ON, 7'd33, 7'd99, 1'b0, 1'b0);
        send_event(REQ_ALL_OFF, 7'd0, 7'd0, 1'b0, 1'b0);
        send_event(REQ_ALL_OFF, 7'd0, 7'd0, 1'b0, 1'b1);
      end else if (phase_mode[p] == MODE_MONO || phase_mode[p] == MODE_LEGATO) begin
        // Overlapping keys slide in legato, a released voice retriggers.
        send_event(REQ_NOTE_ON, 7'd60, 7'd100, 1'b0, 1'b0);
        send_event(REQ_NOTE_ON, 7'd64, 7'd90, 1'b0, 1'b0);
        send_event(REQ_NOTE_OFF, 7'd64, 7'd0, 1'b0, 1'b0);
        send_event(REQ_NOTE_ON, 7'd67, 7'd80, 1'b0, 1'b0);
      end

      band_lo = $urandom_range(0, 127 - 21);
      for (int n = 0; n < RANDOM_EVENTS / NUM_PHASES; n++) send_random_event(band_lo);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_cmds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard limit in case the block stops moving.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Some tests failed");
    $finish;
  end

endmodule
